[sv/rcc_pkg.sv]
// Shared widths, types and codes for the rectangle / circle contact test.
package rcc_pkg;

  localparam int COORD_BITS = 24;
  localparam int RAD_BITS   = COORD_BITS - 1;
  localparam int DIR_BITS   = COORD_BITS + 3;
  localparam int MAG_BITS   = DIR_BITS - 1;
  localparam int TOP_BITS   = $clog2(MAG_BITS);
  localparam int UNIT_SHIFT = 30;
  localparam int SHIFT_BITS = $clog2(UNIT_SHIFT + 1);
  localparam int NORM_BITS  = UNIT_SHIFT + 1;
  localparam int SQ_BITS    = 2 * NORM_BITS;
  localparam int ROOT_BITS  = 64;
  localparam int ROOT_STEPS = 32;
  localparam int LEN_BITS   = ROOT_STEPS;
  localparam int QUO_BITS   = UNIT_SHIFT + 1;
  localparam int REM_BITS   = LEN_BITS + 2;
  localparam int PROD_BITS  = RAD_BITS + QUO_BITS;
  localparam int OFF_BITS   = PROD_BITS - UNIT_SHIFT;
  localparam int CSQ_BITS   = 2 * RAD_BITS;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIR_BITS-1:0]   dir_t;

  typedef enum logic [1:0] {
    KIND_MISS,
    KIND_POINT,
    KIND_DIR
  } kind_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    kind_t                kind;
    coord_t               px;
    coord_t               py;
    logic                 neg_x;
    logic                 neg_y;
    logic [NORM_BITS-1:0] ax;
    logic [NORM_BITS-1:0] ay;
    logic [RAD_BITS-1:0]  rad;
  } rec_t;

endpackage

[sv/rcc_front.sv]
// Front: accepts requests, runs the band and corner tests, normalizes the direction.
module rcc_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  rcc_pkg::coord_t              rect_left,
  input  rcc_pkg::coord_t              rect_top,
  input  rcc_pkg::coord_t              rect_right,
  input  rcc_pkg::coord_t              rect_bottom,
  input  rcc_pkg::coord_t              circle_x,
  input  rcc_pkg::coord_t              circle_y,
  input  logic [rcc_pkg::RAD_BITS-1:0] circle_radius,
  output logic                         rec_valid,
  input  logic                         rec_stall,
  output rcc_pkg::rec_t                rec
);

  // stage A
  logic                             a_v;
  logic                             a_band;
  logic                             a_grow;
  logic                             a_zero;
  logic                             a_negx;
  logic                             a_negy;
  logic [rcc_pkg::MAG_BITS-1:0]     a_mx;
  logic [rcc_pkg::MAG_BITS-1:0]     a_my;
  logic [rcc_pkg::SHIFT_BITS-1:0]   a_shift;
  logic [rcc_pkg::MAG_BITS-1:0]     a_cm [0:7];
  logic [3:0]                       a_inr;
  rcc_pkg::coord_t                  a_l, a_t, a_r, a_b, a_cx, a_cy;
  logic [rcc_pkg::RAD_BITS-1:0]     a_rad;

  // stage B
  logic                             b_v;
  logic                             b_band;
  logic                             b_grow;
  logic                             b_zero;
  logic                             b_negx;
  logic                             b_negy;
  logic [rcc_pkg::NORM_BITS-1:0]    b_ax;
  logic [rcc_pkg::NORM_BITS-1:0]    b_ay;
  logic [rcc_pkg::CSQ_BITS-1:0]     b_sq [0:7];
  logic [rcc_pkg::CSQ_BITS-1:0]     b_rsq;
  logic [3:0]                       b_inr;
  rcc_pkg::coord_t                  b_l, b_t, b_r, b_b, b_cx, b_cy;
  logic [rcc_pkg::RAD_BITS-1:0]     b_rad;

  // stage C
  logic                             c_v;
  rcc_pkg::rec_t                    c_rec;

  logic adv_a, adv_b, adv_c;

  assign adv_c     = !c_v || !rec_stall;
  assign adv_b     = !b_v || adv_c;
  assign adv_a     = !a_v || adv_b;
  assign in_stall  = !adv_a;
  assign rec_valid = c_v;
  assign rec       = c_rec;

  // stage A logic
  rcc_pkg::dir_t lx, tx, rx, bx, cxx, cyx, rd, dx, dy;
  rcc_pkg::dir_t cdx [0:3];
  rcc_pkg::dir_t cdy [0:3];
  logic [rcc_pkg::MAG_BITS-1:0]   mx, my, mm;
  logic [rcc_pkg::MAG_BITS-1:0]   cm [0:7];
  logic [rcc_pkg::TOP_BITS-1:0]   top;
  logic [3:0]                     inr;

  always_comb begin
    lx  = rcc_pkg::dir_t'(rect_left);
    tx  = rcc_pkg::dir_t'(rect_top);
    rx  = rcc_pkg::dir_t'(rect_right);
    bx  = rcc_pkg::dir_t'(rect_bottom);
    cxx = rcc_pkg::dir_t'(circle_x);
    cyx = rcc_pkg::dir_t'(circle_y);
    rd  = {{(rcc_pkg::DIR_BITS - rcc_pkg::RAD_BITS){1'b0}}, circle_radius};
    dx  = lx + rx - (cxx <<< 1);
    dy  = tx + bx - (cyx <<< 1);
    mx  = dx[rcc_pkg::DIR_BITS-1] ? rcc_pkg::MAG_BITS'(-dx) : rcc_pkg::MAG_BITS'(dx);
    my  = dy[rcc_pkg::DIR_BITS-1] ? rcc_pkg::MAG_BITS'(-dy) : rcc_pkg::MAG_BITS'(dy);
    mm  = (mx > my) ? mx : my;
    top = '0;
    for (int i = 0; i < rcc_pkg::MAG_BITS; i++) begin
      if (mm[i]) top = rcc_pkg::TOP_BITS'(i);
    end
    // corners: top-left, top-right, bottom-left, bottom-right
    for (int i = 0; i < 4; i++) begin
      cdx[i] = (((i & 1) != 0) ? rx : lx) - cxx;
      cdy[i] = (((i & 2) != 0) ? bx : tx) - cyx;
      cm[2*i]   = cdx[i][rcc_pkg::DIR_BITS-1] ? rcc_pkg::MAG_BITS'(-cdx[i])
                                              : rcc_pkg::MAG_BITS'(cdx[i]);
      cm[2*i+1] = cdy[i][rcc_pkg::DIR_BITS-1] ? rcc_pkg::MAG_BITS'(-cdy[i])
                                              : rcc_pkg::MAG_BITS'(cdy[i]);
      inr[i] = (cm[2*i] <= rd[rcc_pkg::MAG_BITS-1:0]) &&
               (cm[2*i+1] <= rd[rcc_pkg::MAG_BITS-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (adv_a) begin
      a_v <= in_valid;
    end
    if (adv_a) begin
      a_band  <= (lx <= cxx && cxx <= rx) || (tx <= cyx && cyx <= bx);
      a_grow  <= !((lx - rd > cxx) || (rx + rd < cxx) || (tx - rd > cyx) || (bx + rd < cyx));
      a_zero  <= (dx == '0) && (dy == '0);
      a_negx  <= dx[rcc_pkg::DIR_BITS-1];
      a_negy  <= dy[rcc_pkg::DIR_BITS-1];
      a_mx    <= mx;
      a_my    <= my;
      a_shift <= rcc_pkg::SHIFT_BITS'(rcc_pkg::UNIT_SHIFT) - rcc_pkg::SHIFT_BITS'(top);
      a_cm    <= cm;
      a_inr   <= inr;
      a_l     <= rect_left;
      a_t     <= rect_top;
      a_r     <= rect_right;
      a_b     <= rect_bottom;
      a_cx    <= circle_x;
      a_cy    <= circle_y;
      a_rad   <= circle_radius;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (adv_b) begin
      b_v <= a_v;
    end
    if (adv_b) begin
      b_band <= a_band;
      b_grow <= a_grow;
      b_zero <= a_zero;
      b_negx <= a_negx;
      b_negy <= a_negy;
      b_ax   <= rcc_pkg::NORM_BITS'(a_mx) << a_shift;
      b_ay   <= rcc_pkg::NORM_BITS'(a_my) << a_shift;
      for (int i = 0; i < 8; i++) begin
        // only read when in range, so the magnitude fits the radius width
        b_sq[i] <= rcc_pkg::CSQ_BITS'(a_cm[i][rcc_pkg::RAD_BITS-1:0]) *
                   rcc_pkg::CSQ_BITS'(a_cm[i][rcc_pkg::RAD_BITS-1:0]);
      end
      b_rsq <= rcc_pkg::CSQ_BITS'(a_rad) * rcc_pkg::CSQ_BITS'(a_rad);
      b_inr <= a_inr;
      b_l   <= a_l;
      b_t   <= a_t;
      b_r   <= a_r;
      b_b   <= a_b;
      b_cx  <= a_cx;
      b_cy  <= a_cy;
      b_rad <= a_rad;
    end
  end

  // stage C logic
  rcc_pkg::rec_t c_next;
  logic [3:0]    ok;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ok[i] = b_inr[i] &&
              ({1'b0, b_sq[2*i]} + {1'b0, b_sq[2*i+1]} <= {1'b0, b_rsq});
    end
    c_next       = '0;
    c_next.kind  = rcc_pkg::KIND_MISS;
    c_next.neg_x = b_negx;
    c_next.neg_y = b_negy;
    c_next.ax    = b_ax;
    c_next.ay    = b_ay;
    c_next.rad   = b_rad;
    if (b_band) begin
      if (b_grow) begin
        c_next.kind = b_zero ? rcc_pkg::KIND_POINT : rcc_pkg::KIND_DIR;
        c_next.px   = b_cx;
        c_next.py   = b_cy;
      end
    end else begin
      priority if (ok[0]) begin
        c_next.kind = rcc_pkg::KIND_POINT;
        c_next.px   = b_l;
        c_next.py   = b_t;
      end else if (ok[1]) begin
        c_next.kind = rcc_pkg::KIND_POINT;
        c_next.px   = b_r;
        c_next.py   = b_t;
      end else if (ok[2]) begin
        c_next.kind = rcc_pkg::KIND_POINT;
        c_next.px   = b_l;
        c_next.py   = b_b;
      end else if (ok[3]) begin
        c_next.kind = rcc_pkg::KIND_POINT;
        c_next.px   = b_r;
        c_next.py   = b_b;
      end else begin
        c_next.kind = rcc_pkg::KIND_MISS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (adv_c) begin
      c_v <= b_v;
    end
    if (adv_c) begin
      c_rec <= c_next;
    end
  end

endmodule

[sv/rcc_fifo.sv]
// Short request queue between the front and the back.
module rcc_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_stall,
  input  rcc_pkg::rec_t wr_data,
  output logic          rd_valid,
  input  logic          rd_stall,
  output rcc_pkg::rec_t rd_data
);

  rcc_pkg::rec_t               mem [0:rcc_pkg::FIFO_DEPTH-1];
  logic [rcc_pkg::FIFO_AW-1:0] wr_ptr;
  logic [rcc_pkg::FIFO_AW-1:0] rd_ptr;
  logic [rcc_pkg::FIFO_AW:0]   count;
  logic                        push, pop;

  assign wr_stall = (count == (rcc_pkg::FIFO_AW + 1)'(rcc_pkg::FIFO_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
    if (push) mem[wr_ptr] <= wr_data;
  end

endmodule

[sv/rcc_back.sv]
// Back: square root, unit-vector divide, offset and saturation for band hits.
module rcc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rec_valid,
  output logic                 rec_stall,
  input  rcc_pkg::rec_t        rec,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 hit,
  output rcc_pkg::coord_t      contact_x,
  output rcc_pkg::coord_t      contact_y
);

  localparam int RS = rcc_pkg::ROOT_STEPS;
  localparam int QS = rcc_pkg::QUO_BITS;

  logic en;
  assign en        = !out_valid || !out_stall;
  assign rec_stall = !en;

  // squares, then their sum
  logic                          p0_v, p1_v;
  rcc_pkg::rec_t                 p0_rec, p1_rec;
  logic [rcc_pkg::SQ_BITS-1:0]   p0_sa, p0_sb;
  logic [rcc_pkg::ROOT_BITS-1:0] p1_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_v <= 1'b0;
      p1_v <= 1'b0;
    end else if (en) begin
      p0_v <= rec_valid;
      p1_v <= p0_v;
    end
    if (en) begin
      p0_rec <= rec;
      p0_sa  <= rcc_pkg::SQ_BITS'(rec.ax) * rcc_pkg::SQ_BITS'(rec.ax);
      p0_sb  <= rcc_pkg::SQ_BITS'(rec.ay) * rcc_pkg::SQ_BITS'(rec.ay);
      p1_rec <= p0_rec;
      p1_sum <= rcc_pkg::ROOT_BITS'(p0_sa) + rcc_pkg::ROOT_BITS'(p0_sb);
    end
  end

  // square root, one result bit per stage
  logic                          sq_v   [0:RS-1];
  rcc_pkg::rec_t                 sq_rec [0:RS-1];
  logic [rcc_pkg::ROOT_BITS-1:0] sq_rem [0:RS-1];
  logic [rcc_pkg::ROOT_BITS-1:0] sq_res [0:RS-1];
  logic [rcc_pkg::ROOT_BITS-1:0] si_rem [0:RS-1];
  logic [rcc_pkg::ROOT_BITS-1:0] si_res [0:RS-1];
  logic [rcc_pkg::ROOT_BITS-1:0] sn_rem [0:RS-1];
  logic [rcc_pkg::ROOT_BITS-1:0] sn_res [0:RS-1];
  logic [rcc_pkg::ROOT_BITS-1:0] sbit   [0:RS-1];

  always_comb begin
    for (int k = 0; k < RS; k++) begin
      si_rem[k] = (k == 0) ? p1_sum : sq_rem[(k == 0) ? 0 : k - 1];
      si_res[k] = (k == 0) ? '0     : sq_res[(k == 0) ? 0 : k - 1];
      sbit[k]   = rcc_pkg::ROOT_BITS'(1) << (2 * (RS - 1 - k));
      if (si_rem[k] >= si_res[k] + sbit[k]) begin
        sn_rem[k] = si_rem[k] - si_res[k] - sbit[k];
        sn_res[k] = (si_res[k] >> 1) + sbit[k];
      end else begin
        sn_rem[k] = si_rem[k];
        sn_res[k] = si_res[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < RS; k++) sq_v[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < RS; k++) sq_v[k] <= (k == 0) ? p1_v : sq_v[(k == 0) ? 0 : k - 1];
    end
    if (en) begin
      for (int k = 0; k < RS; k++) begin
        sq_rec[k] <= (k == 0) ? p1_rec : sq_rec[(k == 0) ? 0 : k - 1];
        sq_rem[k] <= sn_rem[k];
        sq_res[k] <= sn_res[k];
      end
    end
  end

  // two restoring dividers, one quotient bit per stage
  logic                         dv_v   [0:QS-1];
  rcc_pkg::rec_t                dv_rec [0:QS-1];
  logic [rcc_pkg::LEN_BITS-1:0] dv_len [0:QS-1];
  logic [rcc_pkg::REM_BITS-1:0] dv_rx  [0:QS-1];
  logic [rcc_pkg::REM_BITS-1:0] dv_ry  [0:QS-1];
  logic [QS-1:0]                dv_qx  [0:QS-1];
  logic [QS-1:0]                dv_qy  [0:QS-1];
  rcc_pkg::rec_t                di_rec [0:QS-1];
  logic [rcc_pkg::LEN_BITS-1:0] di_len [0:QS-1];
  logic [rcc_pkg::REM_BITS-1:0] di_rx  [0:QS-1];
  logic [rcc_pkg::REM_BITS-1:0] di_ry  [0:QS-1];
  logic [QS-1:0]                di_qx  [0:QS-1];
  logic [QS-1:0]                di_qy  [0:QS-1];
  logic [rcc_pkg::REM_BITS-1:0] dsx    [0:QS-1];
  logic [rcc_pkg::REM_BITS-1:0] dsy    [0:QS-1];
  logic [rcc_pkg::REM_BITS-1:0] dn_rx  [0:QS-1];
  logic [rcc_pkg::REM_BITS-1:0] dn_ry  [0:QS-1];
  logic [QS-1:0]                dn_qx  [0:QS-1];
  logic [QS-1:0]                dn_qy  [0:QS-1];

  always_comb begin
    for (int j = 0; j < QS; j++) begin
      if (j == 0) begin
        // numerator is a << UNIT_SHIFT; its upper part is a >> 1, below the divisor
        di_rec[j] = sq_rec[RS-1];
        di_len[j] = sq_res[RS-1][rcc_pkg::LEN_BITS-1:0];
        di_rx[j]  = rcc_pkg::REM_BITS'(sq_rec[RS-1].ax >> 1);
        di_ry[j]  = rcc_pkg::REM_BITS'(sq_rec[RS-1].ay >> 1);
        di_qx[j]  = '0;
        di_qy[j]  = '0;
        dsx[j]    = {di_rx[j][rcc_pkg::REM_BITS-2:0], sq_rec[RS-1].ax[0]};
        dsy[j]    = {di_ry[j][rcc_pkg::REM_BITS-2:0], sq_rec[RS-1].ay[0]};
      end else begin
        di_rec[j] = dv_rec[j-1];
        di_len[j] = dv_len[j-1];
        di_rx[j]  = dv_rx[j-1];
        di_ry[j]  = dv_ry[j-1];
        di_qx[j]  = dv_qx[j-1];
        di_qy[j]  = dv_qy[j-1];
        dsx[j]    = {di_rx[j][rcc_pkg::REM_BITS-2:0], 1'b0};
        dsy[j]    = {di_ry[j][rcc_pkg::REM_BITS-2:0], 1'b0};
      end
      if (dsx[j] >= rcc_pkg::REM_BITS'(di_len[j])) begin
        dn_rx[j] = dsx[j] - rcc_pkg::REM_BITS'(di_len[j]);
        dn_qx[j] = {di_qx[j][QS-2:0], 1'b1};
      end else begin
        dn_rx[j] = dsx[j];
        dn_qx[j] = {di_qx[j][QS-2:0], 1'b0};
      end
      if (dsy[j] >= rcc_pkg::REM_BITS'(di_len[j])) begin
        dn_ry[j] = dsy[j] - rcc_pkg::REM_BITS'(di_len[j]);
        dn_qy[j] = {di_qy[j][QS-2:0], 1'b1};
      end else begin
        dn_ry[j] = dsy[j];
        dn_qy[j] = {di_qy[j][QS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < QS; j++) dv_v[j] <= 1'b0;
    end else if (en) begin
      for (int j = 0; j < QS; j++) dv_v[j] <= (j == 0) ? sq_v[RS-1] : dv_v[(j == 0) ? 0 : j - 1];
    end
    if (en) begin
      for (int j = 0; j < QS; j++) begin
        dv_rec[j] <= di_rec[j];
        dv_len[j] <= di_len[j];
        dv_rx[j]  <= dn_rx[j];
        dv_ry[j]  <= dn_ry[j];
        dv_qx[j]  <= dn_qx[j];
        dv_qy[j]  <= dn_qy[j];
      end
    end
  end

  // radius times unit vector
  logic                          m_v;
  rcc_pkg::rec_t                 m_rec;
  logic [rcc_pkg::PROD_BITS-1:0] m_px, m_py;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (en) begin
      m_v <= dv_v[QS-1];
    end
    if (en) begin
      m_rec <= dv_rec[QS-1];
      m_px  <= rcc_pkg::PROD_BITS'(dv_rec[QS-1].rad) * rcc_pkg::PROD_BITS'(dv_qx[QS-1]);
      m_py  <= rcc_pkg::PROD_BITS'(dv_rec[QS-1].rad) * rcc_pkg::PROD_BITS'(dv_qy[QS-1]);
    end
  end

  // round half up, apply sign, saturate
  logic [rcc_pkg::PROD_BITS-1:0] rnd_x, rnd_y;
  rcc_pkg::dir_t                 off_x, off_y, sum_x, sum_y;
  rcc_pkg::coord_t               sat_x, sat_y;
  logic                          hit_next;
  rcc_pkg::coord_t               cx_next, cy_next;
  rcc_pkg::dir_t                 cmax, cmin;

  always_comb begin
    cmax  = rcc_pkg::dir_t'({1'b0, {(rcc_pkg::COORD_BITS-1){1'b1}}});
    cmin  = rcc_pkg::dir_t'(rcc_pkg::coord_t'({1'b1, {(rcc_pkg::COORD_BITS-1){1'b0}}}));
    rnd_x = m_px + (rcc_pkg::PROD_BITS'(1) << (rcc_pkg::UNIT_SHIFT - 1));
    rnd_y = m_py + (rcc_pkg::PROD_BITS'(1) << (rcc_pkg::UNIT_SHIFT - 1));
    off_x = rcc_pkg::dir_t'({1'b0, rnd_x[rcc_pkg::PROD_BITS-1:rcc_pkg::UNIT_SHIFT]});
    off_y = rcc_pkg::dir_t'({1'b0, rnd_y[rcc_pkg::PROD_BITS-1:rcc_pkg::UNIT_SHIFT]});
    sum_x = m_rec.neg_x ? rcc_pkg::dir_t'(m_rec.px) - off_x : rcc_pkg::dir_t'(m_rec.px) + off_x;
    sum_y = m_rec.neg_y ? rcc_pkg::dir_t'(m_rec.py) - off_y : rcc_pkg::dir_t'(m_rec.py) + off_y;
    sat_x = (sum_x > cmax) ? rcc_pkg::coord_t'(cmax) :
            (sum_x < cmin) ? rcc_pkg::coord_t'(cmin) : rcc_pkg::coord_t'(sum_x);
    sat_y = (sum_y > cmax) ? rcc_pkg::coord_t'(cmax) :
            (sum_y < cmin) ? rcc_pkg::coord_t'(cmin) : rcc_pkg::coord_t'(sum_y);
    unique case (m_rec.kind)
      rcc_pkg::KIND_POINT: begin
        hit_next = 1'b1;
        cx_next  = m_rec.px;
        cy_next  = m_rec.py;
      end
      rcc_pkg::KIND_DIR: begin
        hit_next = 1'b1;
        cx_next  = sat_x;
        cy_next  = sat_y;
      end
      default: begin
        hit_next = 1'b0;
        cx_next  = '0;
        cy_next  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= m_v;
    end
    if (en) begin
      hit       <= hit_next;
      contact_x <= cx_next;
      contact_y <= cy_next;
    end
  end

endmodule

[sv/rect_circle_contact_top.sv]
// Rectangle / circle contact test: accepts requests, returns hit and contact point.
// Throughput is one request per clock while in_stall is low. A request passes the front
// classifier's stages A, B and C, then the 4-entry queue, then the back: the squared length,
// the one-bit-per-stage square root, the two parallel one-bit-per-stage dividers that form
// the unit vector, the radius multiply, and rounding and saturation. Every request, hit or
// miss, travels the same path, so results leave in request order. A stall on the output
// freezes the back pipeline; the queue and front keep taking requests until full.
module rect_circle_contact_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  rcc_pkg::coord_t              rect_left,
  input  rcc_pkg::coord_t              rect_top,
  input  rcc_pkg::coord_t              rect_right,
  input  rcc_pkg::coord_t              rect_bottom,
  input  rcc_pkg::coord_t              circle_x,
  input  rcc_pkg::coord_t              circle_y,
  input  logic [rcc_pkg::RAD_BITS-1:0] circle_radius,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         hit,
  output rcc_pkg::coord_t              contact_x,
  output rcc_pkg::coord_t              contact_y
);

  logic          f_valid, f_stall, q_valid, q_stall;
  rcc_pkg::rec_t f_rec, q_rec;

  rcc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rect_left     (rect_left),
    .rect_top      (rect_top),
    .rect_right    (rect_right),
    .rect_bottom   (rect_bottom),
    .circle_x      (circle_x),
    .circle_y      (circle_y),
    .circle_radius (circle_radius),
    .rec_valid     (f_valid),
    .rec_stall     (f_stall),
    .rec           (f_rec)
  );

  rcc_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_stall (f_stall),
    .wr_data  (f_rec),
    .rd_valid (q_valid),
    .rd_stall (q_stall),
    .rd_data  (q_rec)
  );

  rcc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (q_valid),
    .rec_stall (q_stall),
    .rec       (q_rec),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hit       (hit),
    .contact_x (contact_x),
    .contact_y (contact_y)
  );

endmodule

[sv/rcc_checker.sv]
// Port-level checks for the contact test, bound to the top level.
module rcc_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input logic            hit,
  input rcc_pkg::coord_t contact_x,
  input rcc_pkg::coord_t contact_y
);

  // a miss reports the zero point
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> contact_x == '0 && contact_y == '0)
    else $error("miss with nonzero contact point");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hit) && $stable(contact_x)
                              && $stable(contact_y))
    else $error("stalled result changed");

  // with the output free, input is never refused
  a_no_stall_when_free: assert property (@(posedge clk) disable iff (rst)
    !out_stall && $past(!out_stall) && !$past(rst) |-> !in_stall)
    else $error("input stalled while output is free");

endmodule

bind rect_circle_contact_top rcc_checker u_rcc_checker (.*);

[tb/rect_circle_contact_top_tb.sv]
// Testbench for the rectangle / circle contact block: random and directed requests, checked in order.
`timescale 1ns / 1ps

class contact_scoreboard;
  logic        hit_q[$];
  logic [23:0] cx_q[$];
  logic [23:0] cy_q[$];
  int          mismatches;

  function longint sx(logic [23:0] v);
    sx = longint'(signed'(v));
  endfunction

  function longint clamp(longint v);
    if (v > 64'sd8388607) clamp = 64'sd8388607;
    else if (v < -64'sd8388608) clamp = -64'sd8388608;
    else clamp = v;
  endfunction

  function longint unsigned mag(longint v);
    mag = v < 0 ? -v : v;
  endfunction

  function longint unsigned root(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    root = res;
  endfunction

  function bit corner_touch(longint px, longint py, longint cx, longint cy,
                            longint unsigned r);
    longint unsigned ax, ay;
    ax = mag(px - cx);
    ay = mag(py - cy);
    if (ax > r || ay > r) corner_touch = 0;
    else corner_touch = ax * ax <= r * r - ay * ay;
  endfunction

  // Work out hit and contact point for one accepted request.
  function void note_request(logic [23:0] l_i, t_i, r_i, b_i, x_i, y_i, logic [22:0] rad);
    longint l, t, rr, b, cx, cy, ri, dx, dy, ox, oy, px, py;
    longint unsigned r, ax, ay, m, len, ux, uy;
    longint vx[4], vy[4];
    int top;
    bit h;
    l = sx(l_i); t = sx(t_i); rr = sx(r_i); b = sx(b_i); cx = sx(x_i); cy = sx(y_i);
    r = rad; ri = rad;
    h = 0; px = 0; py = 0;
    if ((l <= cx && cx <= rr) || (t <= cy && cy <= b)) begin
      if (!(l - ri > cx || rr + ri < cx || t - ri > cy || b + ri < cy)) begin
        dx = (l + rr) - 2 * cx;
        dy = (t + b) - 2 * cy;
        h = 1; px = cx; py = cy;
        if (dx != 0 || dy != 0) begin
          ax = mag(dx); ay = mag(dy);
          m = ax > ay ? ax : ay;
          top = 0;
          while ((m >> top) > 1) top++;
          if (top > 30) begin
            ax = ax >> (top - 30); ay = ay >> (top - 30);
          end else begin
            ax = ax << (30 - top); ay = ay << (30 - top);
          end
          len = root(ax * ax + ay * ay);
          ux = (ax << 30) / len;
          uy = (ay << 30) / len;
          ox = longint'((r * ux + (64'd1 << 29)) >> 30);
          oy = longint'((r * uy + (64'd1 << 29)) >> 30);
          px = clamp(dx < 0 ? cx - ox : cx + ox);
          py = clamp(dy < 0 ? cy - oy : cy + oy);
        end
      end
    end else begin
      vx = '{l, rr, l, rr};
      vy = '{t, t, b, b};
      for (int i = 0; i < 4; i++) begin
        if (!h && corner_touch(vx[i], vy[i], cx, cy, r)) begin
          h = 1; px = vx[i]; py = vy[i];
        end
      end
    end
    hit_q.push_back(h);
    cx_q.push_back(px[23:0]);
    cy_q.push_back(py[23:0]);
  endfunction

  function void check_result(logic h, logic [23:0] x, logic [23:0] y);
    logic eh;
    logic [23:0] ex, ey;
    if (hit_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result hit=%0b x=%h y=%h", h, x, y);
      return;
    end
    eh = hit_q.pop_front();
    ex = cx_q.pop_front();
    ey = cy_q.pop_front();
    if (h !== eh || x !== ex || y !== ey) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result: exp hit=%0b x=%h y=%h, got hit=%0b x=%h y=%h",
                 eh, ex, ey, h, x, y);
    end
  endfunction

  function int pending();
    pending = hit_q.size();
  endfunction
endclass

module rect_circle_contact_top_tb;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall, hit;
  rcc_pkg::coord_t rect_left, rect_top, rect_right, rect_bottom, circle_x, circle_y;
  rcc_pkg::coord_t contact_x, contact_y;
  logic [rcc_pkg::RAD_BITS-1:0] circle_radius;
  bit calm;

  contact_scoreboard sb;

  rect_circle_contact_top DUT (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("Mismatches found");
    $finish;
  end

  // Check results and note requests at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result(hit, contact_x, contact_y);
      if (in_valid && !in_stall)
        sb.note_request(rect_left, rect_top, rect_right, rect_bottom, circle_x, circle_y,
                        circle_radius);
    end
  end

  // Stall the output side in bursts.
  initial begin
    int n;
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 7);
        out_stall <= 1;
        repeat (n) @(negedge clk);
        out_stall <= 0;
      end
    end
  end

  task automatic send(rcc_pkg::coord_t l, rcc_pkg::coord_t t, rcc_pkg::coord_t r,
                      rcc_pkg::coord_t b, rcc_pkg::coord_t x, rcc_pkg::coord_t y,
                      logic [rcc_pkg::RAD_BITS-1:0] rad);
    int n;
    if (!calm && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 7);
      in_valid <= 0;
      repeat (n) @(negedge clk);
    end
    rect_left <= l; rect_top <= t; rect_right <= r; rect_bottom <= b;
    circle_x <= x; circle_y <= y; circle_radius <= rad;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Directed requests written with plain integers.
  task automatic send_int(int l, int t, int r, int b, int x, int y, int rad);
    send(rcc_pkg::coord_t'(l), rcc_pkg::coord_t'(t), rcc_pkg::coord_t'(r),
         rcc_pkg::coord_t'(b), rcc_pkg::coord_t'(x), rcc_pkg::coord_t'(y),
         rcc_pkg::RAD_BITS'(rad));
  endtask

  function automatic rcc_pkg::coord_t near(rcc_pkg::coord_t base, int spread);
    near = base + rcc_pkg::coord_t'($urandom_range(0, 2 * spread) - spread);
  endfunction

  task automatic random_request();
    rcc_pkg::coord_t l, t, r, b, x, y;
    logic [rcc_pkg::RAD_BITS-1:0] rad;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      send(rcc_pkg::coord_t'($urandom), rcc_pkg::coord_t'($urandom),
           rcc_pkg::coord_t'($urandom), rcc_pkg::coord_t'($urandom),
           rcc_pkg::coord_t'($urandom), rcc_pkg::coord_t'($urandom),
           rcc_pkg::RAD_BITS'($urandom));
    end else begin
      // Small shapes near each other, so bands, corners and misses all come up.
      l = rcc_pkg::coord_t'($urandom) >>> $urandom_range(0, 16);
      t = rcc_pkg::coord_t'($urandom) >>> $urandom_range(0, 16);
      r = l + rcc_pkg::coord_t'($urandom_range(0, 4000));
      b = t + rcc_pkg::coord_t'($urandom_range(0, 4000));
      if (mode == 9) begin
        r = l - rcc_pkg::coord_t'($urandom_range(1, 500));
      end
      x = near(mode[0] ? l : r, 3000);
      y = near(mode[1] ? t : b, 3000);
      rad = rcc_pkg::RAD_BITS'($urandom_range(0, 3000));
      if (mode == 8) rad = rcc_pkg::RAD_BITS'($urandom);
      send(l, t, r, b, x, y, rad);
    end
  endtask

  initial begin
    int mx, mn, rmax;
    int limit;
    sb = new();
    mx = 8388607;
    mn = -8388608;
    rmax = 8388607;
    calm = 0;
    rst = 1;
    in_valid = 0;
    rect_left = '0; rect_top = '0; rect_right = '0; rect_bottom = '0;
    circle_x = '0; circle_y = '0; circle_radius = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: miss, zero direction, band, corners, inverted, saturation.
    send_int(0, 0, 0, 0, 0, 0, 0);
    send_int(-256, -256, 256, 256, 0, 0, 100);
    send_int(-256, -256, 256, 256, 1000, 0, 800);
    send_int(-256, -256, 256, 256, 0, 1000, 700);
    send_int(-256, -256, 256, 256, 5000, 0, 10);
    send_int(0, 0, 100, 100, -50, -50, 80);
    send_int(0, 0, 100, 100, 150, -50, 80);
    send_int(0, 0, 100, 100, -50, 150, 80);
    send_int(0, 0, 100, 100, 150, 150, 80);
    send_int(0, 0, 100, 100, 150, 150, 70);
    send_int(100, 0, 0, 100, 50, 50, 30);
    send_int(0, 100, 100, 0, 50, 50, 30);
    send_int(mx, mx, mx, mx, mn, mn, rmax);
    send_int(mn, mn, mx, mx, mx, 0, rmax);
    send_int(mn, mn, mn, mx, mx, mx, rmax);
    send_int(mn, mn, mx, mx, mn, mn, rmax);
    send_int(mx, mn, mx, mx, mx - 1, 0, rmax);
    send_int(mn, 0, mn, 0, mn + 5, 0, rmax);
    send_int(0, 0, 0, 0, 3, 4, 5);
    send_int(-1, -1, -1, -1, -1, -1, 0);

    for (int i = 0; i < 400; i++) random_request();
    // Hold off until the pipeline drains.
    in_valid <= 0;
    while (sb.pending() != 0) @(negedge clk);
    for (int i = 0; i < 380; i++) random_request();
    calm = 1;
    for (int i = 0; i < 150; i++) random_request();
    in_valid <= 0;

    limit = 0;
    while (sb.pending() != 0 && limit < 100000) begin
      @(negedge clk);
      limit++;
    end
    repeat (100) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

[sim.f]
sv/rcc_pkg.sv
sv/rcc_front.sv
sv/rcc_fifo.sv
sv/rcc_back.sv
sv/rect_circle_contact_top.sv
sv/rcc_checker.sv
tb/rect_circle_contact_top_tb.sv
